FILE: sv/ppit_pkg.sv
// Shared constants and types of the polygon point-inside test block.
package ppit_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 24;
    localparam int MIN_VERTS        = 3;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic KIND_SIZE   = 1'b0;
    localparam logic KIND_INSIDE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // Per-cycle command to every vertex cell.
    typedef struct packed {
        logic shift;   // push a new vertex in at cell 0
        logic rotate;  // advance the ring of loaded vertices by one place
    } t_cell_ctl;

    // Status of the edge evaluation pipeline.
    typedef struct packed {
        logic pipe_busy;
        logic in_poly;
    } t_edge_stat;

endpackage

FILE: sv/ppit_cell.sv
// One vertex cell of the storage chain: holds one vertex, shifts or rotates.
module ppit_cell #(
    parameter int COORD_BITS = 24,
    parameter int TOT_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                      i_clk,
    input  ppit_pkg::t_cell_ctl       i_ctl,
    input  logic [TOT_W-1:0]          i_total_m1,
    input  logic [COORD_BITS-1:0]     i_down_x,
    input  logic [COORD_BITS-1:0]     i_down_y,
    input  logic [COORD_BITS-1:0]     i_up_x,
    input  logic [COORD_BITS-1:0]     i_up_y,
    input  logic [COORD_BITS-1:0]     i_head_x,
    input  logic [COORD_BITS-1:0]     i_head_y,
    output logic [COORD_BITS-1:0]     o_x,
    output logic [COORD_BITS-1:0]     o_y
);
    import ppit_pkg::*;

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic                  is_end;

    // The cell holding the oldest loaded vertex closes the ring.
    assign is_end = (i_total_m1 == TOT_W'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_down_x;
            r_y <= i_down_y;
        end else if (i_ctl.rotate) begin
            r_x <= is_end ? i_head_x : i_up_x;
            r_y <= is_end ? i_head_y : i_up_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

FILE: sv/ppit_edge.sv
// Three-stage edge crossing evaluator with the even-odd parity register.
module ppit_edge #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_prev_x,
    input  logic signed [COORD_BITS-1:0] i_prev_y,
    input  logic signed [COORD_BITS-1:0] i_cur_x,
    input  logic signed [COORD_BITS-1:0] i_cur_y,
    input  logic signed [COORD_BITS-1:0] i_min_x,
    input  logic signed [COORD_BITS-1:0] i_min_y,
    input  logic signed [COORD_BITS-1:0] i_q_x,
    input  logic signed [COORD_BITS-1:0] i_q_y,
    output ppit_pkg::t_edge_stat         o_stat
);
    import ppit_pkg::*;

    localparam int EW = COORD_BITS + 2;
    localparam int PW = 2 * EW;

    logic signed [EW-1:0] cx, cy, px, py, qx, qy;
    logic signed [EW-1:0] n_a, n_b, n_c, n_d;
    logic                 n_straddle;

    logic signed [EW-1:0] r_a, r_b, r_c, r_d;
    logic                 r_v1, r_st1;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_v2, r_st2, r_bneg;
    logic signed [PW:0]   diff;
    logic                 toggle;
    logic                 r_par;

    // Stage A: shift vertices by the box minimum, form the four factors.
    always_comb begin
        cx = EW'(i_cur_x) - EW'(i_min_x);
        cy = EW'(i_cur_y) - EW'(i_min_y);
        px = EW'(i_prev_x) - EW'(i_min_x);
        py = EW'(i_prev_y) - EW'(i_min_y);
        qx = EW'(i_q_x);
        qy = EW'(i_q_y);
        n_straddle = (cy > qy) != (py > qy);
        n_a = qx - cx;
        n_b = py - cy;
        n_c = px - cx;
        n_d = qy - cy;
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_st1 <= n_straddle;
        // Stage B: both cross products
        r_p1 <= PW'(r_a) * PW'(r_b);
        r_p2 <= PW'(r_c) * PW'(r_d);
        r_st2 <= r_st1;
        r_bneg <= r_b[EW-1];
    end

    // Stage C: exact sign of the product difference, oriented by dy.
    always_comb begin
        diff = (PW+1)'(r_p1) - (PW+1)'(r_p2);
        toggle = r_v2 && r_st2 &&
                 (r_bneg ? (diff > 0) : (diff < 0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_par <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            if (i_clear) begin
                r_par <= 1'b0;
            end else if (toggle) begin
                r_par <= ~r_par;
            end
        end
    end

    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_stat.in_poly   = r_par;

endmodule

FILE: sv/polygon_point_inside_test.sv
// Top level: command decode, bounding box, vertex cell chain and query walk.
// Order: a clear, a last-vertex load or a query on fewer than three vertices
//   raises the strobe via r_pend and then o_strobe; a query on N >= 3 stored
//   vertices raises it after the walk (priming, then every edge issued), the
//   draining of the edge pipeline and the registering of the answer.
// Throughput: one load or clear per cycle while idle; a query walk holds
//   busy while the vertex ring rotates once past the edge unit and that unit drains.
// Reset: synchronous, active low; clears the polygon, box and flags. The
//   receiver cannot stall, so each result beat is shown for one cycle only.
module polygon_point_inside_test #(
    parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    input  logic                         i_is_last,
    output logic                         o_strobe,
    output logic                         o_result_kind,
    output logic                         o_inside_res,
    output logic [COORD_BITS-1:0]        o_box_width,
    output logic [COORD_BITS-1:0]        o_box_height,
    output logic                         o_overflowed
);
    import ppit_pkg::*;

    localparam int TOT_W = $clog2(MAX_VERTICES + 1);

    // Control state
    t_state               r_state, n_state;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [TOT_W-1:0]     r_step;
    logic                 r_set_open, n_set_open;
    logic                 r_drop, n_drop;
    logic                 r_pend, n_pend;
    logic                 r_pend_kind, n_pend_kind;
    logic                 r_pend_inside, n_pend_inside;

    // Bounding box and query operands
    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [COORD_BITS-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;

    logic       acc, acc_query, walk_go, store;
    logic       rotate, issue, done_q;
    t_cell_ctl  cell_ctl;
    t_edge_stat edge_stat;

    logic [COORD_BITS-1:0] cell_x [MAX_VERTICES];
    logic [COORD_BITS-1:0] cell_y [MAX_VERTICES];

    assign busy      = (r_state != ST_IDLE);
    assign acc       = start && !busy;
    assign acc_query = acc && (i_operation == OP_QUERY);
    assign walk_go   = acc_query && (r_total >= TOT_W'(MIN_VERTS));
    // A vertex is kept when it opens a set or there is room left.
    assign store     = !r_set_open || (r_total < TOT_W'(MAX_VERTICES));

    // Next state of the query walk
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (walk_go) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_step == r_total) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!edge_stat.pipe_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Walk outputs: step zero primes the previous vertex, later steps issue edges.
    always_comb begin
        rotate = 1'b0;
        issue  = 1'b0;
        done_q = 1'b0;
        case (r_state)
            ST_IDLE: begin
            end
            ST_WALK: begin
                rotate = (r_step != r_total);
                issue  = (r_step != '0);
            end
            ST_DRAIN: begin
                done_q = !edge_stat.pipe_busy;
            end
            default: begin
            end
        endcase
    end

    assign cell_ctl.shift  = acc && (i_operation == OP_LOAD) && store;
    assign cell_ctl.rotate = rotate;

    // Command decode: polygon bookkeeping and pending report
    always_comb begin
        n_total       = r_total;
        n_set_open    = r_set_open;
        n_drop        = r_drop;
        n_min_x       = r_min_x;
        n_min_y       = r_min_y;
        n_max_x       = r_max_x;
        n_max_y       = r_max_y;
        n_pend        = 1'b0;
        n_pend_kind   = KIND_SIZE;
        n_pend_inside = 1'b0;
        if (acc) begin
            case (i_operation)
                OP_CLEAR: begin
                    n_total    = '0;
                    n_set_open = 1'b0;
                    n_drop     = 1'b0;
                    n_min_x    = '0;
                    n_min_y    = '0;
                    n_max_x    = '0;
                    n_max_y    = '0;
                    n_pend     = 1'b1;
                end
                OP_LOAD: begin
                    if (!r_set_open) begin
                        // first vertex of a set: restart count, flag and box
                        n_total = TOT_W'(1);
                        n_drop  = 1'b0;
                        n_min_x = i_x_coord;
                        n_max_x = i_x_coord;
                        n_min_y = i_y_coord;
                        n_max_y = i_y_coord;
                    end else begin
                        if (i_x_coord < r_min_x) n_min_x = i_x_coord;
                        if (i_x_coord > r_max_x) n_max_x = i_x_coord;
                        if (i_y_coord < r_min_y) n_min_y = i_y_coord;
                        if (i_y_coord > r_max_y) n_max_y = i_y_coord;
                        // drop vertices past capacity but keep widening the box
                        if (store) n_total = r_total + TOT_W'(1);
                        else       n_drop  = 1'b1;
                    end
                    n_set_open = !i_is_last;
                    n_pend     = i_is_last;
                end
                OP_QUERY: begin
                    if (!walk_go) begin
                        // too few vertices: answer outside at once
                        n_pend      = 1'b1;
                        n_pend_kind = KIND_INSIDE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (done_q) begin
            n_pend        = 1'b1;
            n_pend_kind   = KIND_INSIDE;
            n_pend_inside = edge_stat.in_poly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_total    <= '0;
            r_set_open <= 1'b0;
            r_drop     <= 1'b0;
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_pend     <= 1'b0;
            r_step     <= '0;
            o_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_set_open <= n_set_open;
            r_drop     <= n_drop;
            r_min_x    <= n_min_x;
            r_min_y    <= n_min_y;
            r_max_x    <= n_max_x;
            r_max_y    <= n_max_y;
            r_pend     <= n_pend;
            o_strobe   <= r_pend;
            if (walk_go) begin
                r_step <= '0;
            end else if (r_state == ST_WALK) begin
                r_step <= r_step + TOT_W'(1);
            end
        end
    end

    // Payload registers: query operands, previous vertex, result beat
    always_ff @(posedge i_clk) begin
        r_pend_kind   <= n_pend_kind;
        r_pend_inside <= n_pend_inside;
        if (walk_go) begin
            r_qx <= i_x_coord;
            r_qy <= i_y_coord;
        end
        if (r_state == ST_WALK) begin
            r_prev_x <= cell_x[0];
            r_prev_y <= cell_y[0];
        end
        if (r_pend) begin
            o_result_kind <= r_pend_kind;
            o_inside_res  <= r_pend_inside;
            o_box_width   <= COORD_BITS'(r_max_x - r_min_x);
            o_box_height  <= COORD_BITS'(r_max_y - r_min_y);
            o_overflowed  <= r_drop;
        end
    end

    // Vertex cell chain: cell 0 holds the newest vertex and heads the ring.
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        localparam int UP = (k + 1) % MAX_VERTICES;
        logic [COORD_BITS-1:0] down_x, down_y;
        if (k == 0) begin : g_head
            assign down_x = i_x_coord;
            assign down_y = i_y_coord;
        end else begin : g_body
            assign down_x = cell_x[k-1];
            assign down_y = cell_y[k-1];
        end
        ppit_cell #(
            .COORD_BITS (COORD_BITS),
            .TOT_W      (TOT_W),
            .IDX        (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_total_m1 (r_total - TOT_W'(1)),
            .i_down_x   (down_x),
            .i_down_y   (down_y),
            .i_up_x     (cell_x[UP]),
            .i_up_y     (cell_y[UP]),
            .i_head_x   (cell_x[0]),
            .i_head_y   (cell_y[0]),
            .o_x        (cell_x[k]),
            .o_y        (cell_y[k])
        );
    end

    ppit_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (walk_go),
        .i_valid  (issue),
        .i_prev_x (r_prev_x),
        .i_prev_y (r_prev_y),
        .i_cur_x  (cell_x[0]),
        .i_cur_y  (cell_y[0]),
        .i_min_x  (r_min_x),
        .i_min_y  (r_min_y),
        .i_q_x    (r_qx),
        .i_q_y    (r_qy),
        .o_stat   (edge_stat)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the polygon point-inside test block.
`timescale 1ns / 100ps

module testbench;
    import ppit_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int COORD_MIN = -8388608;
    localparam int COORD_MAX = 8388607;
    // Longest stretch with neither an accepted beat nor a result.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to let pass after the last result: a full query walk and margin.
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic        kind;
        logic        in_poly;
        logic [23:0] width;
        logic [23:0] height;
        logic        dropped;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = OP_CLEAR;
    logic signed [23:0] i_x_coord = '0;
    logic signed [23:0] i_y_coord = '0;
    logic        i_is_last   = 1'b0;
    logic        o_strobe;
    logic        o_result_kind;
    logic        o_inside_res;
    logic [23:0] o_box_width;
    logic [23:0] o_box_height;
    logic        o_overflowed;

    polygon_point_inside_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_is_last     (i_is_last),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_inside_res  (o_inside_res),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted polygon state: raw vertices, bounding box and flags.
    // ------------------------------------------------------------------
    int      poly_x [MAX_VERTICES_DEF];
    int      poly_y [MAX_VERTICES_DEF];
    int      n_stored   = 0;
    int      min_x      = 0;
    int      min_y      = 0;
    int      max_x      = 0;
    int      max_y      = 0;
    bit      set_open   = 1'b0;
    bit      drop_seen  = 1'b0;

    t_answer expected_answers [$];
    int      mismatches  = 0;
    int      beats_sent  = 0;  // beats that the block acts on
    int      idle_pct    = 0;  // chance of a sender gap before each beat

    // Even-odd crossing count of a rightward ray from (qx, qy), with the
    // polygon shifted so that the box minimum sits at the origin. Products
    // reach about 51 bits, so 64-bit arithmetic keeps the compare exact.
    function automatic bit point_inside(int qx, int qy);
        bit     odd;
        int     i;
        int     j;
        longint xi, yi, xj, yj, dy, lhs, rhs;
        odd = 1'b0;
        if (n_stored < MIN_VERTS)
            return 1'b0;
        j = n_stored - 1;
        for (i = 0; i < n_stored; i++) begin
            xi = longint'(poly_x[i]) - min_x;
            yi = longint'(poly_y[i]) - min_y;
            xj = longint'(poly_x[j]) - min_x;
            yj = longint'(poly_y[j]) - min_y;
            if ((yi > qy) != (yj > qy)) begin
                dy  = yj - yi;
                lhs = (qx - xi) * dy;
                rhs = (xj - xi) * (qy - yi);
                // crossing strictly right of qx, with the sign of dy folded in
                if (dy > 0 ? lhs < rhs : lhs > rhs)
                    odd = !odd;
            end
            j = i;
        end
        return odd;
    endfunction

    function automatic void push_answer(logic kind, logic in_poly);
        t_answer a;
        a.kind    = kind;
        a.in_poly = in_poly;
        a.width   = 24'(max_x - min_x);
        a.height  = 24'(max_y - min_y);
        a.dropped = drop_seen;
        expected_answers.push_back(a);
    endfunction

    // Advance the predicted state by one accepted beat.
    function automatic void predict_beat(logic [1:0] op, int x, int y, bit is_last);
        case (op)
            OP_CLEAR: begin
                n_stored  = 0;
                min_x     = 0;
                min_y     = 0;
                max_x     = 0;
                max_y     = 0;
                set_open  = 1'b0;
                drop_seen = 1'b0;
                push_answer(KIND_SIZE, 1'b0);
            end
            OP_LOAD: begin
                if (!set_open) begin
                    // first vertex of a new set: restart the box and store
                    n_stored  = 0;
                    drop_seen = 1'b0;
                    min_x     = x;
                    max_x     = x;
                    min_y     = y;
                    max_y     = y;
                    set_open  = 1'b1;
                end else begin
                    if (x < min_x) min_x = x;
                    if (x > max_x) max_x = x;
                    if (y < min_y) min_y = y;
                    if (y > max_y) max_y = y;
                end
                if (n_stored < MAX_VERTICES_DEF) begin
                    poly_x[n_stored] = x;
                    poly_y[n_stored] = y;
                    n_stored++;
                end else begin
                    drop_seen = 1'b1;
                end
                if (is_last) begin
                    set_open = 1'b0;
                    push_answer(KIND_SIZE, 1'b0);
                end
            end
            OP_QUERY: push_answer(KIND_INSIDE, point_inside(x, y));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: each strobed beat against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_strobe) begin
            if (expected_answers.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end else begin
                a = expected_answers.pop_front();
                check_field("result_kind", a.kind, o_result_kind);
                check_field("inside_res", a.in_poly, o_inside_res);
                check_field("box_width", a.width, o_box_width);
                check_field("box_height", a.height, o_box_height);
                check_field("overflowed", a.dropped, o_overflowed);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_strobe) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $error("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Send one beat and hold it until the block takes it. Start stays high
    // afterwards so that back-to-back beats need no drop; a gap drops it.
    // The block sees only the low 24 bits, so predict on the wrapped values.
    task automatic send_beat(logic [1:0] op, int x, int y, bit is_last);
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        sx = 24'(x);
        sy = 24'(y);
        if (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            // mostly short gaps, now and then long enough to span a query walk
            repeat (($urandom_range(7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4))
                @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_x_coord   <= sx;
        i_y_coord   <= sy;
        i_is_last   <= is_last;
        do @(posedge i_clk); while (busy);
        predict_beat(op, int'(sx), int'(sy), is_last);
        if (op != OP_UNUSED)
            beats_sent++;
    endtask

    // Query a point near the current box; some hit a stored vertex exactly
    // so that the straddle rule sees equal y values.
    task automatic query_near_box(int span);
        int idx;
        int margin;
        margin = span / 8 + 1;
        if (n_stored > 0 && $urandom_range(3) == 0) begin
            idx = rand_in(0, n_stored - 1);
            send_beat(OP_QUERY, poly_x[idx] - min_x,
                      ($urandom_range(1)) ? poly_y[idx] - min_y : rand_in(0, span), 1'b0);
        end else begin
            send_beat(OP_QUERY, rand_in(-margin, span + margin),
                      rand_in(-margin, span + margin), 1'b0);
        end
    endtask

    // Load a polygon inside a random window, optionally leaving the set open,
    // with the odd query in the middle of the set, then query it a few times.
    task automatic send_polygon(int n_verts, bit close_set, int span);
        int base_x;
        int base_y;
        int k;
        base_x = rand_in(COORD_MIN, COORD_MAX - span);
        base_y = rand_in(COORD_MIN, COORD_MAX - span);
        for (k = 0; k < n_verts; k++) begin
            send_beat(OP_LOAD, base_x + rand_in(0, span), base_y + rand_in(0, span),
                      close_set && (k == n_verts - 1));
            if ($urandom_range(99) < 8)
                query_near_box(span);
        end
        repeat ($urandom_range(1, 6))
            query_near_box(span);
    endtask

    function automatic int pick_span();
        case ($urandom_range(9))
            0, 1:    return 63;
            2, 3, 4: return 1023;
            5, 6:    return 65535;
            7, 8:    return 4194303;
            default: return 16777215;
        endcase
    endfunction

    function automatic int pick_vertex_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return rand_in(3, 10);
        if (roll < 92) return rand_in(1, 2);
        if (roll < 98) return rand_in(11, MAX_VERTICES_DEF);
        return rand_in(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 6);
    endfunction

    // Extremes, every operation and each corner of the behaviour.
    task automatic test_directed();
        // empty polygon after reset: outside, zero box
        send_beat(OP_QUERY, 0, 0, 1'b0);
        send_beat(OP_UNUSED, COORD_MAX, COORD_MIN, 1'b1);
        // a set of one vertex, closed at once
        send_beat(OP_LOAD, COORD_MIN, COORD_MIN, 1'b1);
        // two vertices, set still open: fewer than three means outside
        send_beat(OP_LOAD, COORD_MIN, COORD_MAX, 1'b0);
        send_beat(OP_LOAD, COORD_MAX, COORD_MIN, 1'b0);
        send_beat(OP_QUERY, 100, 100, 1'b0);
        // close as a full-range triangle
        send_beat(OP_LOAD, COORD_MAX, COORD_MAX, 1'b1);
        send_beat(OP_QUERY, COORD_MAX, COORD_MAX, 1'b0);
        send_beat(OP_QUERY, COORD_MIN, COORD_MIN, 1'b0);
        send_beat(OP_QUERY, COORD_MAX, 4194304, 1'b0);
        send_beat(OP_QUERY, 4194304, COORD_MAX, 1'b0);
        send_beat(OP_CLEAR, 0, 0, 1'b0);
        // small square with a flat top and bottom edge
        send_beat(OP_LOAD, 0, 0, 1'b0);
        send_beat(OP_LOAD, 256, 0, 1'b0);
        send_beat(OP_LOAD, 256, 256, 1'b0);
        send_beat(OP_LOAD, 0, 256, 1'b1);
        send_beat(OP_QUERY, 128, 128, 1'b0);
        send_beat(OP_QUERY, 128, 0, 1'b0);
        send_beat(OP_QUERY, 0, 128, 1'b0);
        send_beat(OP_QUERY, 256, 128, 1'b0);
        send_beat(OP_QUERY, 300, 128, 1'b0);
        send_beat(OP_QUERY, -1, 256, 1'b0);
        send_beat(OP_UNUSED, 0, 0, 1'b0);
        send_beat(OP_CLEAR, COORD_MIN, COORD_MAX, 1'b1);
    endtask

    // Fill past capacity, query the clipped polygon, then check that a new
    // set drops the overflow flag.
    task automatic test_capacity();
        send_polygon(MAX_VERTICES_DEF + 3, 1'b1, 4095);
        send_polygon(MAX_VERTICES_DEF, 1'b1, 1023);
        send_polygon(3, 1'b1, 255);
    endtask

    // Mostly well-formed polygons with random content; the rest is stray
    // loads, open sets, lone queries, clears and ignored codes.
    task automatic test_random(int n_items, int gap_pct);
        int goal;
        int roll;
        idle_pct = gap_pct;
        goal     = beats_sent + n_items;
        while (beats_sent < goal) begin
            roll = $urandom_range(99);
            if (roll < 70)
                send_polygon(pick_vertex_count(), $urandom_range(9) != 0, pick_span());
            else if (roll < 80)
                send_beat(OP_QUERY, rand_in(COORD_MIN, COORD_MAX),
                          rand_in(COORD_MIN, COORD_MAX), $urandom_range(1));
            else if (roll < 88)
                send_beat(OP_CLEAR, rand_in(COORD_MIN, COORD_MAX),
                          rand_in(COORD_MIN, COORD_MAX), $urandom_range(1));
            else if (roll < 93)
                send_beat(OP_UNUSED, rand_in(COORD_MIN, COORD_MAX),
                          rand_in(COORD_MIN, COORD_MAX), $urandom_range(1));
            else
                send_beat(OP_LOAD, rand_in(COORD_MIN, COORD_MAX),
                          rand_in(COORD_MIN, COORD_MAX), $urandom_range(1));
        end
        idle_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random(500, 0);
        test_random(450, 56);
        test_random(450, 27);

        // drop start, wait for every answer, then let any walk finish
        start <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ppit_pkg.sv
sv/ppit_cell.sv
sv/ppit_edge.sv
sv/polygon_point_inside_test.sv
verif/testbench.sv
